>>> design/ascii_debug_serial_transmitter_defines.svh
// Assertion macros shared by the transmitter modules.
// Each macro expands to one labelled concurrent assertion that is
// clocked on the rising edge and switched off while reset is low.
`ifndef ASCII_DEBUG_SERIAL_TRANSMITTER_DEFINES_SVH
`define ASCII_DEBUG_SERIAL_TRANSMITTER_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define ADST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ADST_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> design/adst_pkg.sv
`timescale 1ns / 1ps

package adst_pkg;

  // Frame shape: start bit, eight data bits, then the stop bits.
  localparam int STOP_BITS  = 2;
  localparam int FRAME_BITS = 9 + STOP_BITS;

  // Register file.
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int BIT_TICKS_RST = 5208;
  localparam logic REG_DEBUG_ENABLE = 1'b0;
  localparam logic REG_BIT_TICKS    = 1'b1;

  // Queue between the classifier and the serialiser.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FMT_RAW = 2'd0,
    FMT_HEX = 2'd1,
    FMT_DEC = 2'd2
  } fmt_e;

  typedef struct packed {
    logic       request;
    logic [7:0] data_byte;
    logic [1:0] format;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } out_item_t;

  // A tick after classification: whether its request can queue characters,
  // how many, and the characters themselves.
  typedef struct packed {
    logic            takes;
    logic [1:0]      count;
    logic [2:0][7:0] chars;
  } cls_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

>>> design/ascii_debug_serial_transmitter.sv
`timescale 1ns / 1ps
// Serial transmitter (8 data bits, no parity, two stop bits, LSB first) with
// hex and decimal ASCII formatting, advanced by one timing tick per input
// transaction. Each input transaction carries request, data_byte and format;
// each one yields exactly one output transaction with the line level for that
// tick, the busy flag and whether the request was taken.
// The input front registers and classifies a transaction (raw byte, two hex
// digits and a space, or three decimal digits), a two-entry queue decouples
// it from the serialiser, and the serialiser writes one result per
// transaction into an output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// the result of a transaction passes the front register and then the queue
// entry before the serialiser loads the output register.
// When the receiver stalls, the output register holds its result, the queue
// fills and then the input is stalled; no result is lost or repeated.
// Reset clears the line to idle, empties the queue, disables debug formats and
// sets bit_ticks to 5208. Registers sit at byte addresses 0 (debug_enable) and
// 4 (bit_ticks); the user writes them only while idle, unchecked by the block.

module ascii_debug_serial_transmitter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  adst_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output adst_pkg::out_item_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [adst_pkg::ADDR_W-1:0]         paddr,
  input  logic [adst_pkg::DATA_W-1:0]         pwdata,
  output logic [adst_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import adst_pkg::*;

  // Configuration registers.
  logic        debug_enable_q, debug_enable_d;
  logic [15:0] bit_ticks_q, bit_ticks_d;
  logic        reg_write;
  logic        reg_index;

  // Front to queue and queue to back.
  queue_status_t queue_status;
  cls_item_t     front_item;
  cls_item_t     queue_item;
  logic          push;
  logic          pop;

  assign pready    = 1'b1;
  assign reg_write = psel & penable & pwrite;
  assign reg_index = paddr[2];

  always_comb begin
    debug_enable_d = debug_enable_q;
    bit_ticks_d    = bit_ticks_q;
    if (reg_write) begin
      case (reg_index)
        REG_DEBUG_ENABLE: debug_enable_d = pwdata[0];
        REG_BIT_TICKS:    bit_ticks_d    = pwdata[15:0];
        default: begin
          debug_enable_d = debug_enable_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_DEBUG_ENABLE: prdata = {{(DATA_W - 1){1'b0}}, debug_enable_q};
      REG_BIT_TICKS:    prdata = {{(DATA_W - 16){1'b0}}, bit_ticks_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debug_enable_q <= 1'b0;
      bit_ticks_q    <= 16'(BIT_TICKS_RST);
    end else begin
      debug_enable_q <= debug_enable_d;
      bit_ticks_q    <= bit_ticks_d;
    end
  end

  // The front classifies each tick and formats its characters.
  adst_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .debug_enable_i (debug_enable_q),
    .queue_status_i (queue_status),
    .push_o         (push),
    .item_o         (front_item)
  );

  // The queue lets the front keep taking ticks while a result waits.
  adst_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (queue_item),
    .status_o (queue_status)
  );

  // The back holds the serialiser state and advances the bit timer.
  adst_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_status_i (queue_status),
    .item_i         (queue_item),
    .pop_o          (pop),
    .bit_ticks_i    (bit_ticks_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

>>> design/adst_front.sv
`timescale 1ns / 1ps

module adst_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  adst_pkg::in_item_t  in_data_i,
  input  logic                debug_enable_i,
  input  adst_pkg::queue_status_t queue_status_i,
  output logic                push_o,
  output adst_pkg::cls_item_t item_o
);
  import adst_pkg::*;

  logic      valid_q, valid_d;
  cls_item_t item_q, item_d;
  logic      load;

  logic [7:0]  b;
  logic [1:0]  hundreds;
  logic [6:0]  rest;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  units;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib > 4'h9) begin
      r = {4'h0, nib} + 8'h37;
    end else begin
      r = {4'h0, nib} + 8'h30;
    end
    return r;
  endfunction

  // Decimal split: hundreds by comparison, tens by a reciprocal multiply
  // that is exact for values below one hundred.
  always_comb begin
    b = in_data_i.data_byte;
    if (b >= 8'd200) begin
      hundreds = 2'd2;
      rest     = 7'(b - 8'd200);
    end else if (b >= 8'd100) begin
      hundreds = 2'd1;
      rest     = 7'(b - 8'd100);
    end else begin
      hundreds = 2'd0;
      rest     = b[6:0];
    end
    tens_prod = 15'(rest) * 15'd205;
    tens      = tens_prod[14:11];
    units     = 4'(rest - 7'(tens) * 7'd10);
  end

  always_comb begin
    item_d = '0;
    case (in_data_i.format)
      FMT_RAW: begin
        item_d.takes    = in_data_i.request;
        item_d.count    = 2'd1;
        item_d.chars[0] = in_data_i.data_byte;
      end
      FMT_HEX: begin
        item_d.takes    = in_data_i.request & debug_enable_i;
        item_d.count    = 2'd3;
        item_d.chars[0] = hex_digit(in_data_i.data_byte[7:4]);
        item_d.chars[1] = hex_digit(in_data_i.data_byte[3:0]);
        item_d.chars[2] = 8'h20;
      end
      FMT_DEC: begin
        item_d.takes    = in_data_i.request & debug_enable_i;
        item_d.count    = 2'd3;
        item_d.chars[0] = {6'b001100, hundreds};
        item_d.chars[1] = {4'h3, tens};
        item_d.chars[2] = {4'h3, units};
      end
      default: begin
        item_d = '0;
      end
    endcase
  end

  assign push_o     = valid_q & ~queue_status_i.full;
  assign in_stall_o = valid_q & queue_status_i.full;
  assign load       = in_valid_i & ~in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

endmodule

>>> design/adst_queue.sv
`timescale 1ns / 1ps
`include "ascii_debug_serial_transmitter_defines.svh"

module adst_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  adst_pkg::cls_item_t     item_i,
  input  logic                    pop_i,
  output adst_pkg::cls_item_t     item_o,
  output adst_pkg::queue_status_t status_o
);
  import adst_pkg::*;

  cls_item_t entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_W'(1);
    end
    return r;
  endfunction

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign item_o         = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  `ADST_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && status_o.full, "push into a full queue")
  `ADST_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && status_o.empty, "pop from an empty queue")

endmodule

>>> design/adst_back.sv
`timescale 1ns / 1ps
`include "ascii_debug_serial_transmitter_defines.svh"

module adst_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  adst_pkg::queue_status_t queue_status_i,
  input  adst_pkg::cls_item_t     item_i,
  output logic                    pop_o,
  input  logic [15:0]             bit_ticks_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output adst_pkg::out_item_t     out_data_o
);
  import adst_pkg::*;

  logic [2:0][7:0] chars_q, chars_d;
  logic [1:0]      chars_left_q, chars_left_d;
  logic [3:0]      bit_index_q, bit_index_d;
  logic [15:0]     tick_count_q, tick_count_d;
  logic            sending_q, sending_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic        take;
  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;
  logic [2:0]  bit_sel;
  logic        level;

  assign pop_o = ~queue_status_i.empty & (~out_valid_q | ~out_stall_i);
  assign limit = (bit_ticks_i == '0) ? 16'd1 : bit_ticks_i;

  always_comb begin
    chars_d      = chars_q;
    chars_left_d = chars_left_q;
    bit_index_d  = bit_index_q;
    tick_count_d = tick_count_q;
    sending_d    = sending_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_d        = out_q;
    take         = item_i.takes & ~sending_q;
    tick_inc     = '0;
    bit_inc      = '0;
    bit_sel      = '0;
    level        = 1'b1;

    if (pop_o) begin
      if (take) begin
        chars_d      = item_i.chars;
        chars_left_d = item_i.count;
        bit_index_d  = '0;
        tick_count_d = '0;
        sending_d    = 1'b1;
      end

      if (sending_d) begin
        bit_sel = 3'(bit_index_d - 4'd1);
        if (bit_index_d == '0) begin
          level = 1'b0;
        end else if (bit_index_d <= 4'd8) begin
          level = chars_d[0][bit_sel];
        end else begin
          level = 1'b1;
        end
      end

      out_valid_d      = 1'b1;
      out_d.line_level = level;
      out_d.busy_res   = sending_d;
      out_d.accepted   = take;

      if (sending_d) begin
        tick_inc = tick_count_d + 16'd1;
        bit_inc  = bit_index_d + 4'd1;
        if (tick_inc >= limit) begin
          tick_count_d = '0;
          bit_index_d  = bit_inc;
          if (bit_inc >= 4'(FRAME_BITS)) begin
            bit_index_d  = '0;
            chars_d[0]   = chars_d[1];
            chars_d[1]   = chars_d[2];
            chars_d[2]   = '0;
            chars_left_d = chars_left_d - 2'd1;
            if (chars_left_d == '0) begin
              sending_d = 1'b0;
            end
          end
        end else begin
          tick_count_d = tick_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q      <= '0;
      chars_left_q <= '0;
      bit_index_q  <= '0;
      tick_count_q <= '0;
      sending_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      chars_q      <= chars_d;
      chars_left_q <= chars_left_d;
      bit_index_q  <= bit_index_d;
      tick_count_q <= tick_count_d;
      sending_q    <= sending_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ADST_ASSERT(a_idle_no_chars, clk_i, rst_ni, !sending_q |-> (chars_left_q == '0), "idle with characters left")
  `ADST_ASSERT_NEVER(a_bit_range, clk_i, rst_ni, bit_index_q >= 4'(FRAME_BITS), "bit index beyond frame")
  `ADST_ASSERT(a_accept_busy, clk_i, rst_ni, (out_valid_q && out_q.accepted) |-> out_q.busy_res, "taken request not busy")

endmodule

>>> test/ascii_debug_serial_transmitter_tb.sv
`timescale 1ns / 1ps

module ascii_debug_serial_transmitter_tb;
  import adst_pkg::*;

  // Format code that carries no meaning: the block must ignore such a request.
  localparam logic [1:0] FMT_NONE = 2'd3;

  // Register byte addresses follow the register index, four bytes apart.
  localparam logic [ADDR_W-1:0] DEBUG_ENABLE_ADDR = ADDR_W'(4 * int'(REG_DEBUG_ENABLE));
  localparam logic [ADDR_W-1:0] BIT_TICKS_ADDR    = ADDR_W'(4 * int'(REG_BIT_TICKS));

  // Generous ceiling on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 400000;

  // Scoreboard: a cycle-free model of the transmitter that works out the
  // result of every accepted tick, plus the queue of results still owed.
  class tx_scoreboard;
    logic [7:0]  chars [3];
    logic [1:0]  chars_left;
    logic [3:0]  bit_pos;
    logic [15:0] ticks_in_bit;
    logic        sending;
    logic        dbg_en;
    logic [15:0] ticks_per_bit;
    out_item_t   owed_q[$];
    int unsigned errors;

    function new();
      foreach (chars[i]) chars[i] = '0;
      chars_left    = '0;
      bit_pos       = '0;
      ticks_in_bit  = '0;
      sending       = 1'b0;
      dbg_en        = 1'b0;
      ticks_per_bit = 16'(BIT_TICKS_RST);
      errors        = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == REG_DEBUG_ENABLE) dbg_en = value[0];
      else ticks_per_bit = value[15:0];
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      return (nib > 4'h9) ? 8'(nib) + 8'h37 : 8'(nib) + 8'h30;
    endfunction

    // Advance the model by one accepted tick and queue the result it owes.
    function void note_input(in_item_t it);
      out_item_t   want;
      logic        took;
      logic [15:0] lim;
      took = 1'b0;
      if (it.request && !sending) begin
        case (it.format)
          FMT_RAW: begin
            chars[0]   = it.data_byte;
            chars_left = 2'd1;
            took       = 1'b1;
          end
          FMT_HEX: if (dbg_en) begin
            chars[0]   = hex_char(it.data_byte[7:4]);
            chars[1]   = hex_char(it.data_byte[3:0]);
            chars[2]   = 8'h20;
            chars_left = 2'd3;
            took       = 1'b1;
          end
          FMT_DEC: if (dbg_en) begin
            chars[0]   = 8'(it.data_byte / 100) | 8'h30;
            chars[1]   = 8'((it.data_byte / 10) % 10) | 8'h30;
            chars[2]   = 8'(it.data_byte % 10) | 8'h30;
            chars_left = 2'd3;
            took       = 1'b1;
          end
          default: ;
        endcase
        if (took) begin
          sending      = 1'b1;
          bit_pos      = '0;
          ticks_in_bit = '0;
        end
      end

      // Start bit low, data LSB first, stop bits and idle high.
      want.line_level = 1'b1;
      if (sending) begin
        if (bit_pos == 4'd0) want.line_level = 1'b0;
        else if (bit_pos <= 4'd8) want.line_level = chars[0][bit_pos - 4'd1];
      end
      want.busy_res = sending;
      want.accepted = took;
      owed_q.push_back(want);

      if (sending) begin
        lim          = (ticks_per_bit == '0) ? 16'd1 : ticks_per_bit;
        ticks_in_bit = ticks_in_bit + 16'd1;
        if (ticks_in_bit >= lim) begin
          ticks_in_bit = '0;
          bit_pos      = bit_pos + 4'd1;
          if (bit_pos >= 4'(FRAME_BITS)) begin
            bit_pos    = '0;
            chars[0]   = chars[1];
            chars[1]   = chars[2];
            chars[2]   = '0;
            chars_left = chars_left - 2'd1;
            if (chars_left == '0) sending = 1'b0;
          end
        end
      end
    endfunction

    function void report(string field, logic want, logic got);
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch, expected %b, got %b", $realtime, field, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result %b arrived with nothing expected", $realtime, got);
        return;
      end
      want = owed_q.pop_front();
      if (got.line_level !== want.line_level) report("line_level", want.line_level, got.line_level);
      if (got.busy_res !== want.busy_res) report("busy_res", want.busy_res, got.busy_res);
      if (got.accepted !== want.accepted) report("accepted", want.accepted, got.accepted);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function logic is_busy();
      return sending;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  tx_scoreboard sb;
  int           gap_pct;
  int           stall_pct;
  logic         hold_on;
  int unsigned  cycle_count;

  ascii_debug_serial_transmitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // The receiver stalls at random at the rate of the current phase, and
  // solidly while a long hold-off is running.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  // Every output transaction is checked against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog: a hung block must not keep the run going for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ascii_debug_serial_transmitter_tb: done, errors");
      $finish;
    end
  end

  function automatic in_item_t tick_item(logic req, logic [7:0] b, logic [1:0] f);
    in_item_t it;
    it.request   = req;
    it.data_byte = b;
    it.format    = f;
    return it;
  endfunction

  // Mostly well-formed requests when the line is free, with the odd
  // meaningless format; while busy, now and then a request that must be refused.
  function automatic in_item_t random_tick();
    logic [1:0] f;
    logic       req;
    f   = ($urandom_range(9) == 0) ? FMT_NONE : 2'($urandom_range(2));
    req = sb.is_busy() ? ($urandom_range(99) < 15) : ($urandom_range(99) < 60);
    return tick_item(req, 8'($urandom), f);
  endfunction

  // Offers one tick transaction, the sender idling in each cycle at the
  // rate of the current phase, and returns at the edge at which it is
  // taken. Valid is left high for the next one.
  task automatic push_tick(in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(it);
  endtask

  // Stops offering ticks and waits until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // One write on the register port: a setup phase, then the access phase.
  task automatic write_register(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (idx == REG_DEBUG_ENABLE) ? DEBUG_ENABLE_ADDR : BIT_TICKS_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Waits for the line to fall free, makes one request, then tries another
  // request straight away, refused when the first was taken as the block is busy.
  task automatic send_request(logic [7:0] b, logic [1:0] f);
    while (sb.is_busy()) push_tick(tick_item(1'b0, 8'($urandom), 2'($urandom)));
    push_tick(tick_item(1'b1, b, f));
    push_tick(tick_item(1'b1, ~b, FMT_RAW));
  endtask

  task automatic hold_receiver(int cycles);
    hold_on <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_on <= 1'b0;
  endtask

  // A random phase: set both registers once every owed result is back, choose
  // the idling rates, then run. Under pressure the receiver holds off for a
  // long stretch so that the queue fills, and half way through the sender
  // pauses until every result has come back.
  task automatic run_phase(logic de, logic [15:0] bt, int gap, int stall, int n, bit pressure);
    drain();
    write_register(REG_DEBUG_ENABLE, 32'(de));
    write_register(REG_BIT_TICKS, 32'(bt));
    gap_pct   = gap;
    stall_pct = stall;
    if (pressure) begin
      fork
        hold_receiver(300);
      join_none
    end
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 2) drain();
      push_tick(random_tick());
    end
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    hold_on     = 1'b0;
    cycle_count = 0;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // With the reset settings debug output is off: hex, decimal and the
    // meaningless format are refused, a raw byte is taken, and a second
    // raw request while the first is going out is refused too.
    push_tick(tick_item(1'b1, 8'h5a, FMT_HEX));
    push_tick(tick_item(1'b1, 8'hc3, FMT_DEC));
    push_tick(tick_item(1'b1, 8'h11, FMT_NONE));
    push_tick(tick_item(1'b1, 8'ha5, FMT_RAW));
    push_tick(tick_item(1'b1, 8'h3c, FMT_RAW));
    for (int i = 0; i < 6; i++) push_tick(tick_item(1'b0, 8'($urandom), 2'($urandom)));
    drain();

    // The raw byte is still in its start bit at the slow reset rate, so
    // shortening the bit period here ends that bit at once.
    write_register(REG_BIT_TICKS, 32'd1);
    write_register(REG_DEBUG_ENABLE, 32'd1);

    // Edges of the byte and of each digit range.
    send_request(8'h00, FMT_RAW);
    send_request(8'hff, FMT_RAW);
    send_request(8'h00, FMT_HEX);
    send_request(8'hff, FMT_HEX);
    send_request(8'h9a, FMT_HEX);
    send_request(8'ha9, FMT_HEX);
    send_request(8'd0, FMT_DEC);
    send_request(8'd255, FMT_DEC);
    send_request(8'd100, FMT_DEC);
    send_request(8'd99, FMT_DEC);
    send_request(8'd9, FMT_DEC);
    send_request(8'd10, FMT_DEC);
    send_request(8'h77, FMT_NONE);

    // Random phases over the idling patterns and the register extremes,
    // including a zero bit period and the longest one.
    run_phase(1'b1, 16'd1, 0, 0, 300, 1'b0);
    run_phase(1'b1, 16'd3, 46, 0, 300, 1'b0);
    run_phase(1'b0, 16'd2, 0, 46, 200, 1'b0);
    run_phase(1'b1, 16'd0, 15, 15, 250, 1'b0);
    run_phase(1'b1, 16'hffff, 0, 0, 40, 1'b0);
    run_phase(1'b1, 16'd4, 0, 46, 380, 1'b1);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ascii_debug_serial_transmitter_tb: done, clean");
    end else begin
      $display("ascii_debug_serial_transmitter_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> ascii_debug_serial_transmitter.f
+incdir+design
design/adst_pkg.sv
design/adst_front.sv
design/adst_queue.sv
design/adst_back.sv
design/ascii_debug_serial_transmitter.sv
test/ascii_debug_serial_transmitter_tb.sv
